[src/tudf_pkg.sv]
// ============================================================================
// tudf_pkg: shared types and constants of the tagged unit reply deframer
// Holds the payload structs of both channels, the status codes, the header
// and unit tag values, and the APB address width.
// ============================================================================
package tudf_pkg;

    // Byte tags of the link protocol.
    localparam logic [7:0] TAG_LENGTH_HDR = 8'h1B;
    localparam logic [7:0] TAG_UNIT_BASE  = 8'h1C;
    localparam logic [7:0] TAG_UNIT_MIN   = 8'h1D;
    localparam logic [7:0] TAG_UNIT_MAX   = 8'h1F;
    localparam logic [7:0] READY_FIRST    = 8'h15;

    // Overrun limit is L + L/3 + OVERRUN_SLACK.
    localparam logic [24:0] OVERRUN_SLACK = 25'd16;

    // floor(x/3) == (x * RECIP3) >> RECIP3_SHIFT for every 24-bit x.
    localparam logic [23:0] RECIP3       = 24'hAAAAAB;
    localparam int          RECIP3_SHIFT = 25;

    localparam int          PADDR_W      = 3;
    localparam logic [23:0] MAX_LEN_RESET = 24'hFFFFFF;

    // Final status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_HDR_TAG  = 3'd1;
    localparam logic [2:0] ST_SHORT_HDR    = 3'd2;
    localparam logic [2:0] ST_ZERO_LEN     = 3'd3;
    localparam logic [2:0] ST_TOO_LONG     = 3'd4;
    localparam logic [2:0] ST_BAD_UNIT_TAG = 3'd5;
    localparam logic [2:0] ST_OVERRUN      = 3'd6;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd7;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_transfer;
    } tudf_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       done_res;
        logic [2:0] status;
        logic       send_ack;
    } tudf_out_t;

    // Result of one parse step.
    typedef struct packed {
        logic      fire;
        tudf_out_t res;
    } tudf_step_t;

endpackage

[src/tudf_cfg.sv]
// ============================================================================
// tudf_cfg: APB configuration register
// Holds max_reply_length; writes land on the access cycle, reads return the
// stored value when the top paddr bit is clear and zero otherwise.
// ============================================================================
module tudf_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tudf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [23:0]                  max_len
);
    import tudf_pkg::*;

    logic [23:0] max_len_reg;
    logic [23:0] max_len_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en) begin
            max_len_next = pwdata[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata  = (paddr[PADDR_W-1] == 1'b0) ? {8'd0, max_len_reg} : 32'd0;
    assign max_len = max_len_reg;

endmodule

[src/tudf_parse.sv]
// ============================================================================
// tudf_parse: header and unit parser
// Holds the frame state and decides, for one byte, the next state and
// whether a result transaction is produced.
// ============================================================================
module tudf_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  tudf_pkg::tudf_in_t   in_data,
    input  logic [23:0]          max_len,
    output tudf_pkg::tudf_step_t step
);
    import tudf_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [1:0]  hidx_reg,     hidx_next;
    logic        hready_reg,   hready_next;
    logic        htag_ok_reg,  htag_ok_next;
    logic [23:0] len_reg,      len_next;
    logic [24:0] copied_reg,   copied_next;
    logic [25:0] recv_reg,     recv_next;
    logic [1:0]  upos_reg,     upos_next;
    logic [1:0]  upc_reg,      upc_next;
    logic [2:0]  err_reg,      err_next;

    // Overrun limit, recomputed every cycle from the held length. It settles
    // through prod_reg and then limit_reg, well before sixteen data bytes.
    logic [47:0] prod_reg;
    logic [24:0] limit_reg;
    logic [24:0] limit_next;

    logic [7:0]  b;
    logic        eot;
    logic [7:0]  tag_diff;
    logic        clear;
    logic        has;
    logic [2:0]  st;

    assign b        = in_data.rx_byte;
    assign eot      = in_data.end_of_transfer;
    assign tag_diff = b - TAG_UNIT_BASE;

    assign limit_next = {1'b0, len_reg} + {2'b0, prod_reg[47:RECIP3_SHIFT]} + OVERRUN_SLACK;

    always_ff @(posedge aclk) begin
        prod_reg  <= len_reg * RECIP3;
        limit_reg <= limit_next;
    end

    always_comb begin
        phase_next   = phase_reg;
        hidx_next    = hidx_reg;
        hready_next  = hready_reg;
        htag_ok_next = htag_ok_reg;
        len_next     = len_reg;
        copied_next  = copied_reg;
        recv_next    = recv_reg;
        upos_next    = upos_reg;
        upc_next     = upc_reg;
        err_next     = err_reg;
        clear        = 1'b0;
        has          = 1'b0;
        st           = ST_OK;
        step         = '0;

        if (step_en) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hidx_reg == 2'd0) begin
                        hready_next  = hready_reg && (b == READY_FIRST);
                        htag_ok_next = (b == TAG_LENGTH_HDR);
                    end else begin
                        hready_next = hready_reg && (b == 8'd0);
                        len_next    = {len_reg[15:0], b};
                    end

                    if (hidx_reg != 2'd3) begin
                        if (eot) begin
                            clear               = 1'b1;
                            step.fire           = 1'b1;
                            step.res.done_res   = 1'b1;
                            step.res.status     = ST_SHORT_HDR;
                        end else begin
                            hidx_next = hidx_reg + 2'd1;
                        end
                    end else if (hready_next) begin
                        // Ready signal from the device: nothing to report.
                        clear = 1'b1;
                    end else begin
                        if (!htag_ok_reg) begin
                            st = ST_BAD_HDR_TAG;
                        end else if (len_next == 24'd0) begin
                            st = ST_ZERO_LEN;
                        end else if (len_next > max_len) begin
                            st = ST_TOO_LONG;
                        end
                        if (st != ST_OK) begin
                            clear             = 1'b1;
                            step.fire         = 1'b1;
                            step.res.done_res = 1'b1;
                            step.res.status   = st;
                        end else begin
                            phase_next  = PH_DATA;
                            hidx_next   = 2'd0;
                            copied_next = '0;
                            recv_next   = '0;
                            upos_next   = 2'd0;
                            upc_next    = 2'd0;
                            err_next    = ST_OK;
                        end
                    end
                end

                PH_DATA: begin
                    if (recv_reg >= {1'b0, limit_reg}) begin
                        clear             = 1'b1;
                        step.fire         = 1'b1;
                        step.res.done_res = 1'b1;
                        step.res.status   = ST_OVERRUN;
                    end else begin
                        recv_next = recv_reg + 26'd1;
                        if (upos_reg == 2'd0) begin
                            upc_next = 2'd0;
                            // Tags are checked only while payload is still owed.
                            if (err_reg == ST_OK && copied_reg < {1'b0, len_reg}) begin
                                if (b >= TAG_UNIT_MIN && b <= TAG_UNIT_MAX) begin
                                    upc_next = tag_diff[1:0];
                                end else begin
                                    err_next = ST_BAD_UNIT_TAG;
                                end
                            end
                        end else if (upos_reg <= upc_reg) begin
                            has         = (copied_reg < {1'b0, len_reg});
                            copied_next = copied_reg + 25'd1;
                        end
                        upos_next = upos_reg + 2'd1;

                        if (eot) begin
                            st = err_next;
                            if (st == ST_OK && copied_next != {1'b0, len_reg}) begin
                                st = ST_LEN_MISMATCH;
                            end
                            clear              = 1'b1;
                            step.fire          = 1'b1;
                            step.res.data_byte = has ? b : 8'd0;
                            step.res.has_data  = has;
                            step.res.done_res  = 1'b1;
                            step.res.status    = st;
                            step.res.send_ack  = 1'b1;
                        end else if (has) begin
                            step.fire          = 1'b1;
                            step.res.data_byte = b;
                            step.res.has_data  = 1'b1;
                        end
                    end
                end

                default: begin
                    clear = 1'b1;
                end
            endcase
        end

        if (clear) begin
            phase_next   = PH_HEADER;
            hidx_next    = 2'd0;
            hready_next  = 1'b1;
            htag_ok_next = 1'b0;
            len_next     = '0;
            copied_next  = '0;
            recv_next    = '0;
            upos_next    = 2'd0;
            upc_next     = 2'd0;
            err_next     = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hidx_reg    <= 2'd0;
            hready_reg  <= 1'b1;
            htag_ok_reg <= 1'b0;
            len_reg     <= '0;
            copied_reg  <= '0;
            recv_reg    <= '0;
            upos_reg    <= 2'd0;
            upc_reg     <= 2'd0;
            err_reg     <= ST_OK;
        end else begin
            phase_reg   <= phase_next;
            hidx_reg    <= hidx_next;
            hready_reg  <= hready_next;
            htag_ok_reg <= htag_ok_next;
            len_reg     <= len_next;
            copied_reg  <= copied_next;
            recv_reg    <= recv_next;
            upos_reg    <= upos_next;
            upc_reg     <= upc_next;
            err_reg     <= err_next;
        end
    end

endmodule

[src/tagged_unit_reply_deframer_core.sv]
// ============================================================================
// tagged_unit_reply_deframer_core: reply deframer top level
// Strips the length header and unit tags from received bytes, streams the
// payload bytes and reports the final status with an ack request.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_data  (rx_byte, end_of_transfer)
//  m_        out        m_valid/m_ready    m_data  (data_byte, has_data,
//                                                   done_res, status, send_ack)
//  APB       in         psel/penable       max_reply_length at address 0
//
// One byte is taken per cycle while s_ready is high; a result passes through
// the input register, then the result register after the parse logic.
// A byte that yields no result still passes through the input register.
// When the result register is full and m_ready is low, the input register
// holds its byte and s_ready drops once it is occupied.
// Reset is synchronous on aresetn low and returns the parser to the header.
module tagged_unit_reply_deframer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tudf_pkg::tudf_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tudf_pkg::tudf_out_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tudf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tudf_pkg::*;

    logic       in_valid_reg, in_valid_next;
    tudf_in_t   in_data_reg;
    logic       out_valid_reg, out_valid_next;
    tudf_out_t  out_data_reg;
    logic       advance;
    logic [23:0] max_len;
    tudf_step_t step;

    tudf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    tudf_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_data (in_data_reg),
        .max_len (max_len),
        .step    (step)
    );

    // The held byte moves on only when the result slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && step.fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && step.fire) begin
            out_data_reg <= step.res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The input stage only stalls while it holds a byte.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("s_ready low with an empty input stage");

    // A status or ack request only comes with a completed reply.
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK || m_data.send_ack) |-> m_data.done_res)
        else $error("status or ack without completion");

    // Every result carries either a byte or a completion.
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_data || m_data.done_res))
        else $error("empty result transaction");

    // A stalled byte leaves the input stage unchanged.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage changed while stalled");

endmodule

[tb/tb_tagged_unit_reply_deframer_core.sv]
// ============================================================================
// tb_tagged_unit_reply_deframer_core: self-checking bench for the deframer
// Feeds reply byte streams (ready signals, broken headers, tagged data units,
// truncated, padded, over-long and overrunning replies) through the valid/ready
// input, predicts every payload byte and final status, and checks the output
// stream in order while both sides stall at random.
// ============================================================================
module tb_tagged_unit_reply_deframer_core;
    import tudf_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_MAX_REPLY_LEN = '0;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tudf_in_t            s_data;
    logic                m_valid;
    logic                m_ready;
    tudf_out_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tudf_in_t  pending_rx[$];
    tudf_out_t predicted_out[$];
    int        pushed_bytes = 0;
    int        mismatches = 0;
    int        results_seen = 0;

    // Stall state of both sides.
    int tx_gap = 0;
    int tx_burst = 0;
    int rx_gap = 0;
    int rx_burst = 0;
    int hold_left = 0;
    bit long_hold_done = 0;

    // Shadow of the parser state.
    logic [23:0] max_len_cfg;
    bit          in_data_phase;
    logic [1:0]  hdr_pos;
    bit          hdr_ready_seq;
    bit          hdr_tag_seen;
    logic [23:0] frame_len;
    int unsigned copied_bytes;
    int unsigned seen_bytes;
    logic [1:0]  unit_slot;
    logic [1:0]  unit_len;
    logic [2:0]  frame_err;

    tagged_unit_reply_deframer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void restart_frame();
        in_data_phase = 1'b0;
        hdr_pos = '0;
        hdr_ready_seq = 1'b1;
        hdr_tag_seen = 1'b0;
        frame_len = '0;
        copied_bytes = 0;
        seen_bytes = 0;
        unit_slot = '0;
        unit_len = '0;
        frame_err = ST_OK;
    endfunction

    // Advances the shadow parser by one byte; returns 1 when an output is due.
    function automatic bit deframe_step(input tudf_in_t item, output tudf_out_t res);
        logic [7:0]  b;
        bit          eot;
        logic [7:0]  want;
        logic [2:0]  st;
        int unsigned lim;
        bit          has;
        res = '0;
        b = item.rx_byte;
        eot = item.end_of_transfer;
        if (!in_data_phase) begin
            want = (hdr_pos == 0) ? READY_FIRST : 8'h00;
            if (b != want) hdr_ready_seq = 1'b0;
            if (hdr_pos == 0) hdr_tag_seen = (b == TAG_LENGTH_HDR);
            else frame_len = {frame_len[15:0], b};
            if (hdr_pos < 3) begin
                if (eot) begin
                    restart_frame();
                    res.done_res = 1'b1;
                    res.status = ST_SHORT_HDR;
                    return 1'b1;
                end
                hdr_pos = hdr_pos + 2'd1;
                return 1'b0;
            end
            if (hdr_ready_seq) begin
                restart_frame();
                return 1'b0;
            end
            st = ST_OK;
            if (!hdr_tag_seen) st = ST_BAD_HDR_TAG;
            else if (frame_len == 0) st = ST_ZERO_LEN;
            else if (frame_len > max_len_cfg) st = ST_TOO_LONG;
            if (st != ST_OK) begin
                restart_frame();
                res.done_res = 1'b1;
                res.status = st;
                return 1'b1;
            end
            in_data_phase = 1'b1;
            hdr_pos = '0;
            copied_bytes = 0;
            seen_bytes = 0;
            unit_slot = '0;
            unit_len = '0;
            frame_err = ST_OK;
            return 1'b0;
        end

        lim = frame_len + frame_len / 3 + 16;
        if (seen_bytes + 1 > lim) begin
            restart_frame();
            res.done_res = 1'b1;
            res.status = ST_OVERRUN;
            return 1'b1;
        end
        seen_bytes = seen_bytes + 1;
        has = 1'b0;
        if (unit_slot == 0) begin
            unit_len = '0;
            // Tags are only checked while payload is still owed.
            if (frame_err == ST_OK && copied_bytes < frame_len) begin
                if (b >= TAG_UNIT_MIN && b <= TAG_UNIT_MAX) unit_len = 2'(b - TAG_UNIT_BASE);
                else frame_err = ST_BAD_UNIT_TAG;
            end
        end else if (unit_slot <= unit_len) begin
            if (copied_bytes < frame_len) has = 1'b1;
            copied_bytes = copied_bytes + 1;
        end
        unit_slot = unit_slot + 2'd1;

        if (eot) begin
            st = frame_err;
            if (st == ST_OK && copied_bytes != frame_len) st = ST_LEN_MISMATCH;
            restart_frame();
            res.data_byte = has ? b : 8'h00;
            res.has_data = has;
            res.done_res = 1'b1;
            res.status = st;
            res.send_ack = 1'b1;
            return 1'b1;
        end
        if (has) begin
            res.data_byte = b;
            res.has_data = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run without any.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    always @(posedge aclk) begin : drive_rx
        bit        busy;
        tudf_out_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                if (deframe_step(s_data, res)) predicted_out.push_back(res);
                busy = 1'b0;
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_rx.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_rx.pop_front();
                    tx_gap = pick_gap(tx_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_out
        tudf_out_t want;
        bit        bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output: byte %h has %b done %b status %0d ack %b",
                                 m_data.data_byte, m_data.has_data, m_data.done_res,
                                 m_data.status, m_data.send_ack);
                end else begin
                    want = predicted_out.pop_front();
                    bad = (m_data.data_byte !== want.data_byte) ||
                          (m_data.has_data !== want.has_data) ||
                          (m_data.done_res !== want.done_res) ||
                          (m_data.status !== want.status) ||
                          (m_data.send_ack !== want.send_ack);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("output %0d: expected byte %h has %b done %b status %0d ack %b",
                                     results_seen, want.data_byte, want.has_data,
                                     want.done_res, want.status, want.send_ack);
                            $display("    got byte %h has %b done %b status %0d ack %b",
                                     m_data.data_byte, m_data.has_data, m_data.done_res,
                                     m_data.status, m_data.send_ack);
                        end
                    end
                end
            end
            // One long hold while the sender still has plenty queued, so the
            // block backs up into its input.
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 60 && pending_rx.size() > 40) begin
                long_hold_done = 1'b1;
                hold_left = 300;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap = pick_gap(rx_burst);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit eot);
        pending_rx.push_back(tudf_in_t'{rx_byte: b, end_of_transfer: eot});
        pushed_bytes++;
    endtask

    task automatic push_header(input logic [7:0] tag, input logic [23:0] len, input bit eot);
        push_byte(tag, 1'b0);
        push_byte(len[23:16], 1'b0);
        push_byte(len[15:8], 1'b0);
        push_byte(len[7:0], eot);
    endtask

    // Waits until every queued byte is taken and every predicted output has
    // arrived, then lets the pipeline settle for bytes that give no output.
    task automatic wait_idle();
        while (pending_rx.size() != 0 || s_valid || predicted_out.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_max_len(input logic [23:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_REPLY_LEN;
        pwdata <= {8'h00, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        max_len_cfg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[23:0] !== value) begin
            mismatches++;
            if (mismatches <= 10)
                $display("max_reply_length read back %h, expected %h", prdata[23:0], value);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Queues one reply, either well-formed or broken in one way or another.
    task automatic queue_reply();
        int          kind;
        int          variant;
        int          n;
        int          c;
        int          rem;
        int          top;
        int          lim;
        int          small_used;
        int          units;
        int          k;
        bit          oversize;
        logic [7:0]  bad;
        logic [23:0] hlen;
        logic [7:0]  body[$];
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            push_header(READY_FIRST, 24'h000000, 1'($urandom_range(0, 1)));
        end else if (kind < 8) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte((i == 0 && $urandom_range(0, 1)) ? TAG_LENGTH_HDR
                                                            : 8'($urandom_range(0, 255)),
                          i == n - 1);
        end else if (kind < 11) begin
            bad = 8'($urandom_range(0, 255));
            if (bad == TAG_LENGTH_HDR) bad = 8'h1A;
            push_header(bad, 24'($urandom), 1'($urandom_range(0, 1)));
        end else if (kind < 14) begin
            push_header(TAG_LENGTH_HDR, 24'h000000, 1'($urandom_range(0, 1)));
        end else if (kind < 18) begin
            if (max_len_cfg != 24'hFFFFFF) begin
                hlen = 24'($urandom_range(max_len_cfg + 1, 24'hFFFFFF));
                push_header(TAG_LENGTH_HDR, hlen, 1'($urandom_range(0, 1)));
            end else begin
                // A huge accepted length that ends far too early.
                hlen = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom_range(256, 24'hFFFFFF));
                push_header(TAG_LENGTH_HDR, hlen, 1'b0);
                n = $urandom_range(1, 3);
                for (int i = 0; i < 4 * n; i++)
                    push_byte((i % 4 == 0) ? TAG_UNIT_MAX : 8'($urandom_range(0, 255)),
                              i == 4 * n - 1);
            end
        end else if (kind < 22) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end else begin
            if (max_len_cfg == 0) begin
                hlen = 24'($urandom_range(1, 40));
            end else begin
                top = (max_len_cfg < 40) ? int'(max_len_cfg) : 40;
                hlen = ($urandom_range(0, 9) == 0) ? 24'(top) : 24'($urandom_range(1, top));
            end
            push_header(TAG_LENGTH_HDR, hlen, 1'b0);
            if (hlen > max_len_cfg) return;
            variant = $urandom_range(0, 99);
            oversize = (variant >= 45 && variant < 55);
            rem = int'(hlen);
            small_used = 0;
            units = 0;
            // At most three short units keeps a correct reply inside the
            // overrun slack.
            while (rem > 0) begin
                c = 3;
                if (small_used < 3 && $urandom_range(0, 4) == 0) begin
                    c = $urandom_range(1, 2);
                    small_used++;
                end
                if (c > rem && !oversize) c = rem;
                body.push_back(8'(TAG_UNIT_BASE + c));
                for (int i = 0; i < 3; i++) body.push_back(8'($urandom_range(0, 255)));
                rem = (c < rem) ? rem - c : 0;
                units++;
            end
            lim = hlen + hlen / 3 + 16;
            if (variant >= 55 && variant < 65) begin
                n = 4 * $urandom_range(1, 3);
                while (n > 0 && body.size() < lim) begin
                    body.push_back(8'($urandom_range(0, 255)));
                    n--;
                end
            end else if (variant >= 65 && variant < 75) begin
                k = $urandom_range(1, body.size() - 1);
                body = body[0:k-1];
            end else if (variant >= 75 && variant < 85) begin
                k = $urandom_range(0, units - 1);
                case ($urandom_range(0, 3))
                    0: bad = 8'h00;
                    1: bad = TAG_UNIT_BASE;
                    2: bad = 8'hFF;
                    default: bad = 8'($urandom_range(0, 255));
                endcase
                if (bad >= TAG_UNIT_MIN && bad <= TAG_UNIT_MAX) bad = 8'h20;
                body[4 * k] = bad;
            end else if (variant >= 85) begin
                while (body.size() < lim + 1) body.push_back(8'($urandom_range(0, 255)));
            end
            for (int i = 0; i < body.size(); i++)
                push_byte(body[i], (i == body.size() - 1) &&
                                   (variant < 85 || $urandom_range(0, 1)));
        end
    endtask

    task automatic queue_replies(input int count);
        int start;
        start = pushed_bytes;
        while (pushed_bytes - start < count) queue_reply();
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        max_len_cfg = MAX_LEN_RESET;
        restart_frame();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ready signal, with the end mark on its last byte ignored.
        push_header(READY_FIRST, 24'h000000, 1'b1);
        // Header cut short by the end mark.
        push_byte(TAG_LENGTH_HDR, 1'b0);
        push_byte(8'h00, 1'b1);
        // Bad header tag, then a zero length.
        push_header(8'hFF, 24'h000001, 1'b0);
        push_header(TAG_LENGTH_HDR, 24'h000000, 1'b0);
        // Three payload bytes in one unit, the last one carrying the end mark.
        push_header(TAG_LENGTH_HDR, 24'h000003, 1'b0);
        push_byte(TAG_UNIT_MAX, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h5A, 1'b1);
        wait_idle();

        write_max_len(24'h000000);
        queue_replies(80);
        wait_idle();

        write_max_len(24'd24);
        queue_replies(260);
        wait_idle();

        write_max_len(24'($urandom_range(25, 48)));
        queue_replies(130);
        wait_idle();
        queue_replies(130);
        wait_idle();

        write_max_len(24'hFFFFFF);
        queue_replies(260);
        wait_idle();
        repeat (10) @(negedge aclk);

        if (mismatches == 0 && predicted_out.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
